FILE: hdl/assert_macros.svh
// assertion helpers for the rtl files, included by the receiver statistics block
// expects clk and rst_n in scope at the point of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/utr_pkg.sv
// constants shared by the receiver statistics block
// no dependencies
`default_nettype none

package utr_pkg;

  localparam int SEQ_W      = 32;
  localparam int LEN_W      = 16;
  localparam int TIME_W     = 32;
  localparam int ADDR_W     = 64;
  localparam int PORT_W     = 16;
  localparam int CNT_W      = 32;
  localparam int SEC_W      = 13;
  localparam int USEC_W     = 20;

  // reset value of the length limit
  localparam logic [LEN_W-1:0] MAX_LEN_RST = 16'd2048;

  // one second in microseconds
  localparam logic [USEC_W-1:0] USEC_PER_SEC = 20'd1000000;

  // ceil(2^50 / 1e6); exact quotient for every 32-bit dividend
  localparam int                 USEC_RECIP_W = 31;
  localparam logic [USEC_RECIP_W-1:0] USEC_RECIP = 31'h431BDE83;
  localparam int                 USEC_SHIFT   = 50;
  localparam int                 PROD_W       = TIME_W + USEC_RECIP_W;

endpackage

`default_nettype wire

FILE: hdl/utr_in_if.sv
// input channel: one received test datagram per beat
// depends on utr_pkg
`default_nettype none

interface utr_in_if;
  import utr_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [SEQ_W-1:0]  seq_number;
  logic [LEN_W-1:0]         packet_length;
  logic [TIME_W-1:0]        arrival_time_us;
  logic [ADDR_W-1:0]        sender_addr_high;
  logic [ADDR_W-1:0]        sender_addr_low;
  logic [PORT_W-1:0]        sender_port;

  modport source (
    output valid, seq_number, packet_length, arrival_time_us,
           sender_addr_high, sender_addr_low, sender_port,
    input  ready
  );

  modport sink (
    input  valid, seq_number, packet_length, arrival_time_us,
           sender_addr_high, sender_addr_low, sender_port,
    output ready
  );
endinterface

`default_nettype wire

FILE: hdl/utr_out_if.sv
// result channel: one end-of-test report per beat
// depends on utr_pkg
`default_nettype none

interface utr_out_if;
  import utr_pkg::*;

  logic                valid;
  logic                ready;
  logic [ADDR_W-1:0]   reply_addr_high;
  logic [ADDR_W-1:0]   reply_addr_low;
  logic [PORT_W-1:0]   reply_port;
  logic [CNT_W-1:0]    report_bytes;
  logic [SEC_W-1:0]    report_seconds;
  logic [USEC_W-1:0]   report_micros;
  logic [CNT_W-1:0]    report_lost;
  logic [CNT_W-1:0]    report_reordered;
  logic [CNT_W-1:0]    report_packets;

  modport source (
    output valid, reply_addr_high, reply_addr_low, reply_port, report_bytes,
           report_seconds, report_micros, report_lost, report_reordered,
           report_packets,
    input  ready
  );

  modport sink (
    input  valid, reply_addr_high, reply_addr_low, reply_port, report_bytes,
           report_seconds, report_micros, report_lost, report_reordered,
           report_packets,
    output ready
  );
endinterface

`default_nettype wire

FILE: hdl/udp_throughput_test_receiver_stats.sv
// Receiver statistics for a UDP bandwidth test. Each input beat is one
// received datagram; the block takes one beat per clock unless stalled, and
// a report beat passes the input register, the stats register, then the
// two registered stages of the constant divide by one million that splits
// the duration into seconds and microseconds. The whole pipeline holds
// while the report register is full and not taken; the input register
// still catches one more beat. Datagrams longer than the configured limit
// leave all counters untouched. A non-positive sequence number ends the
// test, emits the report to the sender and clears the packet and byte
// counts; the reorder count is cleared only by reset.
// depends on utr_pkg, utr_in_if, utr_out_if, utr_usec_split, assert_macros.svh
`default_nettype none

module udp_throughput_test_receiver_stats (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  utr_in_if.sink                          in_ch,
  utr_out_if.source                       out_ch,
  input  wire logic                       cfg_wr_en,
  input  wire logic [utr_pkg::LEN_W-1:0]  cfg_wr_data
);
  import utr_pkg::*;

  // pipeline control
  logic adv;
  logic in_ready;
  logic s0_valid_r;
  logic s1_valid_r;
  logic s2_valid_r;
  logic out_valid_r;

  // configuration
  logic [LEN_W-1:0] max_len_r;

  // input register
  logic [SEQ_W-1:0]  s0_seq_r;
  logic [LEN_W-1:0]  s0_len_r;
  logic [TIME_W-1:0] s0_time_r;
  logic [ADDR_W-1:0] s0_addr_hi_r;
  logic [ADDR_W-1:0] s0_addr_lo_r;
  logic [PORT_W-1:0] s0_port_r;

  // test state
  logic [SEQ_W-1:0]  last_seq_r;
  logic [CNT_W-1:0]  pkt_cnt_r;
  logic [CNT_W-1:0]  byte_cnt_r;
  logic [TIME_W-1:0] start_time_r;
  logic [CNT_W-1:0]  reorder_cnt_r;
  logic [CNT_W-1:0]  pkt_cnt_nxt;
  logic [CNT_W-1:0]  byte_cnt_nxt;
  logic [CNT_W-1:0]  reorder_cnt_nxt;

  // stats stage decode
  logic              frame_keep;
  logic              seq_pos;
  logic              seq_one;
  logic              upd;
  logic [SEQ_W-1:0]  next_exp;
  logic [CNT_W-1:0]  pkt_inc;
  logic [CNT_W-1:0]  byte_inc;
  logic [CNT_W-1:0]  lost_nxt;
  logic              s1_valid_nxt;

  // report stages
  logic [ADDR_W-1:0] s1_addr_hi_r, s2_addr_hi_r, out_addr_hi_r;
  logic [ADDR_W-1:0] s1_addr_lo_r, s2_addr_lo_r, out_addr_lo_r;
  logic [PORT_W-1:0] s1_port_r,    s2_port_r,    out_port_r;
  logic [CNT_W-1:0]  s1_bytes_r,   s2_bytes_r,   out_bytes_r;
  logic [CNT_W-1:0]  s1_lost_r,    s2_lost_r,    out_lost_r;
  logic [CNT_W-1:0]  s1_reord_r,   s2_reord_r,   out_reord_r;
  logic [CNT_W-1:0]  s1_pkts_r,    s2_pkts_r,    out_pkts_r;
  logic [TIME_W-1:0] s1_dur_r;
  logic [SEC_W-1:0]  out_sec_r;
  logic [USEC_W-1:0] out_usec_r;

  // whole pipeline moves unless the report register is stuck
  assign adv      = !out_valid_r || out_ch.ready;
  assign in_ready = !s0_valid_r || adv;
  assign in_ch.ready = in_ready;

  // frame classification
  assign frame_keep = s0_len_r <= max_len_r;
  assign seq_pos    = !s0_seq_r[SEQ_W-1] && (s0_seq_r != '0);
  assign seq_one    = s0_seq_r == {{(SEQ_W-1){1'b0}}, 1'b1};
  assign upd        = s0_valid_r && adv && frame_keep;

  // counters including this frame
  assign next_exp = last_seq_r + {{(SEQ_W-1){1'b0}}, 1'b1};
  assign pkt_inc  = pkt_cnt_r + {{(CNT_W-1){1'b0}}, 1'b1};
  assign byte_inc = byte_cnt_r + {{(CNT_W-LEN_W){1'b0}}, s0_len_r};
  assign lost_nxt = (next_exp > pkt_inc) ? (next_exp - pkt_inc) : '0;

  // end frame clears the per-test counts
  assign pkt_cnt_nxt  = seq_pos ? pkt_inc  : '0;
  assign byte_cnt_nxt = seq_pos ? byte_inc : '0;
  assign reorder_cnt_nxt = (seq_pos && (s0_seq_r != next_exp))
                         ? reorder_cnt_r + {{(CNT_W-1){1'b0}}, 1'b1}
                         : reorder_cnt_r;

  assign s1_valid_nxt = s0_valid_r && frame_keep && !seq_pos;

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r    <= 1'b0;
      s1_valid_r    <= 1'b0;
      s2_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      max_len_r     <= MAX_LEN_RST;
      last_seq_r    <= '0;
      pkt_cnt_r     <= '0;
      byte_cnt_r    <= '0;
      start_time_r  <= '0;
      reorder_cnt_r <= '0;
    end else begin
      if (in_ready) begin
        s0_valid_r <= in_ch.valid;
      end
      if (adv) begin
        s1_valid_r  <= s1_valid_nxt;
        s2_valid_r  <= s1_valid_r;
        out_valid_r <= s2_valid_r;
      end
      if (cfg_wr_en) begin
        max_len_r <= cfg_wr_data;
      end
      if (upd) begin
        last_seq_r    <= s0_seq_r;
        pkt_cnt_r     <= pkt_cnt_nxt;
        byte_cnt_r    <= byte_cnt_nxt;
        reorder_cnt_r <= reorder_cnt_nxt;
        if (seq_one) begin
          start_time_r <= s0_time_r;
        end
      end
    end
  end

  // input register payload
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ready) begin
      s0_seq_r     <= in_ch.seq_number;
      s0_len_r     <= in_ch.packet_length;
      s0_time_r    <= in_ch.arrival_time_us;
      s0_addr_hi_r <= in_ch.sender_addr_high;
      s0_addr_lo_r <= in_ch.sender_addr_low;
      s0_port_r    <= in_ch.sender_port;
    end
  end

  // report payload through the divide stages
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_addr_hi_r <= s0_addr_hi_r;
      s1_addr_lo_r <= s0_addr_lo_r;
      s1_port_r    <= s0_port_r;
      s1_bytes_r   <= byte_inc;
      s1_lost_r    <= lost_nxt;
      s1_reord_r   <= reorder_cnt_r;
      s1_pkts_r    <= pkt_inc;
      s1_dur_r     <= s0_time_r - start_time_r;

      s2_addr_hi_r <= s1_addr_hi_r;
      s2_addr_lo_r <= s1_addr_lo_r;
      s2_port_r    <= s1_port_r;
      s2_bytes_r   <= s1_bytes_r;
      s2_lost_r    <= s1_lost_r;
      s2_reord_r   <= s1_reord_r;
      s2_pkts_r    <= s1_pkts_r;

      out_addr_hi_r <= s2_addr_hi_r;
      out_addr_lo_r <= s2_addr_lo_r;
      out_port_r    <= s2_port_r;
      out_bytes_r   <= s2_bytes_r;
      out_lost_r    <= s2_lost_r;
      out_reord_r   <= s2_reord_r;
      out_pkts_r    <= s2_pkts_r;
    end
  end

  // duration to seconds and microseconds
  utr_usec_split u_split (
    .clk    (clk),
    .en     (adv),
    .dur_us (s1_dur_r),
    .sec_r  (out_sec_r),
    .usec_r (out_usec_r)
  );

  // result channel
  assign out_ch.valid            = out_valid_r;
  assign out_ch.reply_addr_high  = out_addr_hi_r;
  assign out_ch.reply_addr_low   = out_addr_lo_r;
  assign out_ch.reply_port       = out_port_r;
  assign out_ch.report_bytes     = out_bytes_r;
  assign out_ch.report_seconds   = out_sec_r;
  assign out_ch.report_micros    = out_usec_r;
  assign out_ch.report_lost      = out_lost_r;
  assign out_ch.report_reordered = out_reord_r;
  assign out_ch.report_packets   = out_pkts_r;

  // checks
  `include "assert_macros.svh"

  `ASSERT_NEXT(a_end_clears, upd && !seq_pos, (pkt_cnt_r == '0) && (byte_cnt_r == '0), "end frame left counts")
  `ASSERT_NEXT(a_drop_holds, s0_valid_r && adv && !frame_keep, $stable(pkt_cnt_r) && $stable(last_seq_r), "oversized frame changed state")
  `ASSERT_NEXT(a_start_latch, upd && seq_one, start_time_r == $past(s0_time_r), "start time not latched")
  `ASSERT_SAME(a_usec_range, out_valid_r, out_usec_r < USEC_PER_SEC, "microseconds out of range")

endmodule

`default_nettype wire

FILE: hdl/utr_usec_split.sv
// two-stage split of a microsecond duration into seconds and microseconds
// reciprocal multiply, then remainder by multiply and subtract; uses utr_pkg
`default_nettype none

module utr_usec_split (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic [utr_pkg::TIME_W-1:0]  dur_us,
  output logic      [utr_pkg::SEC_W-1:0]   sec_r,
  output logic      [utr_pkg::USEC_W-1:0]  usec_r
);
  import utr_pkg::*;

  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] prod_nxt;
  logic [TIME_W-1:0] dur_r;
  logic [SEC_W-1:0]  quot;
  logic [TIME_W-1:0] whole_us;
  logic [TIME_W-1:0] rem_us;

  // stage 1: duration times reciprocal
  assign prod_nxt = {{(PROD_W-TIME_W){1'b0}}, dur_us}
                  * {{(PROD_W-USEC_RECIP_W){1'b0}}, USEC_RECIP};

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      dur_r  <= dur_us;
    end
  end

  // stage 2: quotient from the high bits, remainder by back-multiply
  assign quot     = prod_r[USEC_SHIFT +: SEC_W];
  assign whole_us = {{(TIME_W-SEC_W){1'b0}}, quot}
                  * {{(TIME_W-USEC_W){1'b0}}, USEC_PER_SEC};
  assign rem_us   = dur_r - whole_us;

  always_ff @(posedge clk) begin
    if (en) begin
      sec_r  <= quot;
      usec_r <= rem_us[USEC_W-1:0];
    end
  end

endmodule

`default_nettype wire

FILE: tb/udp_throughput_test_receiver_stats_test.sv
// testbench for the udp receiver statistics block: drives datagram beats,
// predicts the end-of-test reports and checks them field by field
// depends on utr_pkg, utr_in_if, utr_out_if and udp_throughput_test_receiver_stats
`timescale 1ns / 100ps

module udp_throughput_test_receiver_stats_test;
  import utr_pkg::*;

  typedef struct {
    logic [SEQ_W-1:0]  seq_number;
    logic [LEN_W-1:0]  packet_length;
    logic [TIME_W-1:0] arrival_time_us;
    logic [ADDR_W-1:0] sender_addr_high;
    logic [ADDR_W-1:0] sender_addr_low;
    logic [PORT_W-1:0] sender_port;
  } datagram_t;

  typedef struct {
    logic [ADDR_W-1:0] reply_addr_high;
    logic [ADDR_W-1:0] reply_addr_low;
    logic [PORT_W-1:0] reply_port;
    logic [CNT_W-1:0]  report_bytes;
    logic [SEC_W-1:0]  report_seconds;
    logic [USEC_W-1:0] report_micros;
    logic [CNT_W-1:0]  report_lost;
    logic [CNT_W-1:0]  report_reordered;
    logic [CNT_W-1:0]  report_packets;
  } report_t;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [LEN_W-1:0] cfg_wr_data;

  utr_in_if  in_ch ();
  utr_out_if out_ch ();

  udp_throughput_test_receiver_stats i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // mirror of the receiver state
  logic [LEN_W-1:0] len_limit;
  logic [31:0] prev_seq;
  logic [31:0] pkt_total;
  logic [31:0] byte_total;
  logic [31:0] test_start_us;
  logic [31:0] reorder_total;

  report_t reports_due[$];
  logic [31:0] now_us;
  int sender_gap_pct;
  int sink_stall_pct;
  int err_cnt;
  int offered_cnt;
  int counted_cnt;
  int checked_cnt;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #5ms;
    $display("timeout while waiting for report beats");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // update the mirrored counters for one taken datagram; returns 1 with a report
  function automatic bit tally_datagram(input datagram_t d, output report_t r);
    logic [31:0] prior;
    logic [31:0] next_exp;
    logic [31:0] span;
    bit data_frame;
    r = '{default: '0};
    if (d.packet_length > len_limit) return 1'b0;
    prior = prev_seq;
    prev_seq = d.seq_number;
    pkt_total = pkt_total + 32'd1;
    byte_total = byte_total + 32'(d.packet_length);
    next_exp = prior + 32'd1;
    data_frame = !d.seq_number[31] && (d.seq_number != 32'd0);
    if (data_frame) begin
      if (d.seq_number == 32'd1) test_start_us = d.arrival_time_us;
      if (d.seq_number != next_exp) reorder_total = reorder_total + 32'd1;
      return 1'b0;
    end
    // end frame: build the report, then clear the per-test counts
    span = d.arrival_time_us - test_start_us;
    r.reply_addr_high  = d.sender_addr_high;
    r.reply_addr_low   = d.sender_addr_low;
    r.reply_port       = d.sender_port;
    r.report_bytes     = byte_total;
    r.report_seconds   = SEC_W'(span / 32'(USEC_PER_SEC));
    r.report_micros    = USEC_W'(span % 32'(USEC_PER_SEC));
    r.report_lost      = (next_exp > pkt_total) ? next_exp - pkt_total : 32'd0;
    r.report_reordered = reorder_total;
    r.report_packets   = pkt_total;
    pkt_total = 32'd0;
    byte_total = 32'd0;
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      err_cnt++;
    end
  endfunction

  // result side: random stalls and report checking
  always @(posedge clk) begin
    report_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (reports_due.size() == 0) begin
        $error("report beat with no report pending");
        err_cnt++;
      end else begin
        want = reports_due.pop_front();
        checked_cnt++;
        check_field("reply_addr_high", want.reply_addr_high, out_ch.reply_addr_high);
        check_field("reply_addr_low", want.reply_addr_low, out_ch.reply_addr_low);
        check_field("reply_port", want.reply_port, out_ch.reply_port);
        check_field("report_bytes", want.report_bytes, out_ch.report_bytes);
        check_field("report_seconds", want.report_seconds, out_ch.report_seconds);
        check_field("report_micros", want.report_micros, out_ch.report_micros);
        check_field("report_lost", want.report_lost, out_ch.report_lost);
        check_field("report_reordered", want.report_reordered, out_ch.report_reordered);
        check_field("report_packets", want.report_packets, out_ch.report_packets);
      end
    end
    out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // send one datagram beat; valid stays high after acceptance
  task automatic send_datagram(input datagram_t d);
    report_t r;
    while ($urandom_range(99) < sender_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid            <= 1'b1;
    in_ch.seq_number       <= d.seq_number;
    in_ch.packet_length    <= d.packet_length;
    in_ch.arrival_time_us  <= d.arrival_time_us;
    in_ch.sender_addr_high <= d.sender_addr_high;
    in_ch.sender_addr_low  <= d.sender_addr_low;
    in_ch.sender_port      <= d.sender_port;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    offered_cnt++;
    if (d.packet_length <= len_limit) counted_cnt++;
    if (tally_datagram(d, r)) reports_due.push_back(r);
  endtask

  // drop valid, drain all pending reports and let the pipeline empty
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (reports_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_max_len(input logic [LEN_W-1:0] value);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    len_limit = value;
  endtask

  function automatic datagram_t make_datagram(input logic [31:0] seq,
                                              input logic [15:0] len,
                                              input logic [31:0] t_us);
    datagram_t d;
    d.seq_number       = seq;
    d.packet_length    = len;
    d.arrival_time_us  = t_us;
    d.sender_addr_high = {$urandom, $urandom};
    d.sender_addr_low  = {$urandom, $urandom};
    d.sender_port      = 16'($urandom);
    return d;
  endfunction

  // mostly legal lengths, with boundary and oversized ones mixed in
  function automatic logic [15:0] pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 8 && len_limit != 16'hFFFF) return 16'($urandom_range(int'(len_limit) + 1, 65535));
    if (r < 15) return len_limit;
    if (r < 20) return 16'd0;
    return 16'($urandom_range(0, int'(len_limit)));
  endfunction

  function automatic void advance_clock();
    if ($urandom_range(49) == 0) now_us = $urandom;
    else now_us = now_us + 32'($urandom_range(0, 3000));
  endfunction

  // data frames with occasional skips, repeats and steps back, then an end frame
  task automatic play_session(input int n_data, input bit from_one);
    logic [31:0] seq;
    logic [31:0] end_seq;
    int k;
    seq = from_one ? 32'd1 : {1'b0, 31'($urandom)};
    for (k = 0; k < n_data; k++) begin
      advance_clock();
      send_datagram(make_datagram(seq, pick_length(), now_us));
      case ($urandom_range(19))
        0: seq = seq + 32'($urandom_range(2, 4));
        1: seq = seq;
        2: seq = seq - 32'd1;
        default: seq = seq + 32'd1;
      endcase
    end
    case ($urandom_range(3))
      0: end_seq = 32'd0;
      1: end_seq = 32'hFFFF_FFFF;
      2: end_seq = 32'h8000_0000;
      default: end_seq = {1'b1, 31'($urandom)};
    endcase
    advance_clock();
    send_datagram(make_datagram(end_seq, pick_length(), now_us));
  endtask

  // length limit at reset value, zero and maximum, address and port extremes
  task automatic test_length_limit();
    datagram_t d;
    send_datagram(make_datagram(32'd1, 16'd0, 32'd100));
    send_datagram(make_datagram(32'd2, 16'd2048, 32'd150));
    send_datagram(make_datagram(32'd3, 16'd2049, 32'd200));
    send_datagram(make_datagram(32'd5, 16'd1, 32'd250));
    d = make_datagram(32'd0, 16'd17, 32'd1_000_300);
    d.sender_addr_high = '1;
    d.sender_addr_low  = '1;
    d.sender_port      = '1;
    send_datagram(d);

    write_max_len(16'd0);
    send_datagram(make_datagram(32'd1, 16'd0, 32'd10));
    send_datagram(make_datagram(32'd2, 16'd1, 32'd20));
    d = make_datagram(32'hFFFF_FFFF, 16'd0, 32'd30);
    d.sender_addr_high = '0;
    d.sender_addr_low  = '0;
    d.sender_port      = '0;
    send_datagram(d);

    write_max_len(16'hFFFF);
    send_datagram(make_datagram(32'd1, 16'hFFFF, 32'd0));
    send_datagram(make_datagram(32'd2, 16'h8000, 32'd999_999));
    send_datagram(make_datagram(32'h8000_0000, 16'hFFFF, 32'd2_000_000));
    wait_idle();
  endtask

  // duration wrap, end without start, sequence at maximum, longest duration
  task automatic test_special_cases();
    send_datagram(make_datagram(32'd1, 16'd10, 32'hFFFF_FFF0));
    send_datagram(make_datagram(32'd2, 16'd10, 32'h0000_0005));
    send_datagram(make_datagram(32'd0, 16'd10, 32'h0000_0010));
    send_datagram(make_datagram(32'hFFFF_FFFB, 16'd3, 32'h0001_0000));
    send_datagram(make_datagram(32'h7FFF_FFFF, 16'd4, 32'd50));
    send_datagram(make_datagram(32'd5, 16'd4, 32'd60));
    send_datagram(make_datagram(32'h7FFF_FFFF, 16'd4, 32'd70));
    send_datagram(make_datagram(32'hFFFF_FFFF, 16'd4, 32'd80));
    send_datagram(make_datagram(32'd0, 16'd4, 32'd90));
    send_datagram(make_datagram(32'd1, 16'd1, 32'd1));
    send_datagram(make_datagram(32'd0, 16'd1, 32'd0));
    wait_idle();
  endtask

  // random sessions, broken sessions and noise at one limit and idling mix
  task automatic test_random_traffic(input int gap_pct, input int stall_pct,
                                     input logic [15:0] lim, input int n_items);
    int goal;
    int halfway;
    bit paused;
    int pick;
    sender_gap_pct = gap_pct;
    sink_stall_pct = stall_pct;
    write_max_len(lim);
    goal = counted_cnt + n_items;
    halfway = counted_cnt + n_items / 2;
    paused = 1'b0;
    while (counted_cnt < goal) begin
      // hold the sender until every pending report is out
      if (!paused && counted_cnt >= halfway) begin
        wait_idle();
        paused = 1'b1;
      end
      pick = $urandom_range(9);
      if (pick < 7) begin
        play_session($urandom_range(1, 12), 1'b1);
      end else if (pick == 7) begin
        play_session($urandom_range(0, 6), 1'b0);
      end else begin
        send_datagram(make_datagram($urandom, 16'($urandom_range(0, 65535)), $urandom));
      end
    end
    wait_idle();
  endtask

  // main sequence
  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_ch.valid = 1'b0;
    in_ch.seq_number = '0;
    in_ch.packet_length = '0;
    in_ch.arrival_time_us = '0;
    in_ch.sender_addr_high = '0;
    in_ch.sender_addr_low = '0;
    in_ch.sender_port = '0;
    out_ch.ready = 1'b0;
    len_limit = MAX_LEN_RST;
    prev_seq = '0;
    pkt_total = '0;
    byte_total = '0;
    test_start_us = '0;
    reorder_total = '0;
    now_us = $urandom;
    sender_gap_pct = 36;
    sink_stall_pct = 57;
    err_cnt = 0;
    offered_cnt = 0;
    counted_cnt = 0;
    checked_cnt = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_length_limit();
    test_special_cases();
    test_random_traffic(36, 57, 16'd1500, 130);
    test_random_traffic(57, 36, 16'hFFFF, 130);
    test_random_traffic(0, 0, 16'd300, 130);

    if (reports_due.size() != 0) begin
      $error("%0d reports never arrived", reports_due.size());
      err_cnt++;
    end
    $display("offered %0d datagrams (%0d within the length limit), checked %0d reports",
             offered_cnt, counted_cnt, checked_cnt);
    $display("limits 0, 300, 1500, 2048 and 65535 under three idling mixes");
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
